/* rtl/core/ohpi_pkg.sv */
`default_nettype none

package ohpi_pkg;

    // Operation codes
    localparam logic OP_ODOM = 1'b0;
    localparam logic OP_YAW  = 1'b1;

    // Angles in unsigned Q30 radians, used only when the sine table is built
    localparam logic [63:0] PI_Q30      = 64'd3373259426;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] TWO_PI_Q30  = 64'd6746518852;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;

    // Quarter turn as a binary angle
    localparam logic [15:0] QUARTER_TURN = 16'h4000;

    typedef struct packed {
        logic               operation;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] yaw_increment;
    } t_in;

    typedef struct packed {
        logic signed [31:0] pose_x;
        logic signed [31:0] pose_y;
        logic signed [31:0] pose_z;
        logic signed [15:0] heading;
        logic signed [15:0] orient_w;
        logic signed [15:0] orient_z;
    } t_out;

    // Q14 sine of an angle in [0, 2*pi) given in Q30; evaluated at elaboration only.
    function automatic logic signed [15:0] sine_q14(input logic [63:0] ang);
        logic [63:0] t;
        logic [63:0] x2;
        logic [63:0] r;
        logic [63:0] s;
        logic [63:0] q;
        logic        neg;
        t   = ang;
        neg = 1'b0;
        if (t >= PI_Q30) begin
            neg = 1'b1;
            t   = t - PI_Q30;
        end
        if (t > HALF_PI_Q30) begin
            t = PI_Q30 - t;
        end
        x2 = (t * t) >> 30;
        r  = ONE_Q30;
        r  = ONE_Q30 - (((x2 * r) >> 30) / 64'd156);
        r  = ONE_Q30 - (((x2 * r) >> 30) / 64'd110);
        r  = ONE_Q30 - (((x2 * r) >> 30) / 64'd72);
        r  = ONE_Q30 - (((x2 * r) >> 30) / 64'd42);
        r  = ONE_Q30 - (((x2 * r) >> 30) / 64'd20);
        r  = ONE_Q30 - (((x2 * r) >> 30) / 64'd6);
        s  = (t * r) >> 30;
        q  = (s + 64'd32768) >> 16;
        if (q > 64'd16384) begin
            q = 64'd16384;
        end
        if (neg) begin
            q = -q;
        end
        return q[15:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/core/odometry_heading_pose_integrator.sv */
`default_nettype none

// Dead-reckoning pose integrator. A heading transaction (operation = 1) adds its
// binary-angle increment to the current heading and returns nothing.
// In an odometry transaction (operation = 0) the displacement
// from the previous odometry sample (zero on the first) is rotated into the
// previous sample's body frame by the transposed matrix of that sample's
// quaternion, rotated about z by the heading latched at the previous odometry
// transaction, and added to the saturating pose. Its result carries the pose,
// the current heading and the heading quaternion (w, z). The steps, on one
// shared 18x40 signed multiplier, are ten quaternion products, a matrix
// rounding step, nine matrix-vector MACs and four heading-rotation MACs,
// then the pose update. The sine table (SINE_TABLE_DEPTH
// entries over a full turn) is read through one registered port during the
// quaternion products. The input side is ready only while the sequencer is idle;
// a finished result sits in the output register and does not block the next
// input, but a later odometry result waits until the previous one is taken.
module odometry_heading_pose_integrator #(
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    input  wire ohpi_pkg::t_in i_in,
    output logic              o_out_valid,
    input  wire               i_out_ready,
    output ohpi_pkg::t_out    o_out
);
    import ohpi_pkg::*;

    localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_PROD   = 6'b000010,
        S_MATRIX = 6'b000100,
        S_LOC    = 6'b001000,
        S_ROT    = 6'b010000,
        S_ADD    = 6'b100000
    } t_state;

    t_state r_state;

    // Sine table, built at elaboration
    logic signed [15:0] w_sine [SINE_TABLE_DEPTH];
    for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_sine
        localparam logic [63:0] ANG = (64'(k) * TWO_PI_Q30) / 64'(SINE_TABLE_DEPTH);
        assign w_sine[k] = sine_q14(ANG);
    end

    // Architectural state
    logic signed [31:0] r_prev_p [3];
    logic signed [15:0] r_prev_q [4];
    logic               r_seen;
    logic signed [31:0] r_fused [3];
    logic        [15:0] r_head_now;
    logic        [15:0] r_head_last;

    // Working registers
    logic        [3:0]  r_step;
    logic        [1:0]  r_row;
    logic        [1:0]  r_col;
    logic signed [32:0] r_d [3];
    logic signed [15:0] r_q [4];
    logic signed [29:0] r_prod [10];
    logic signed [17:0] r_m [3][3];
    logic signed [38:0] r_loc [3];
    logic signed [45:0] r_g [2];
    logic signed [59:0] r_acc;
    logic signed [15:0] r_rom_q;
    logic signed [15:0] r_trig [4]; // cos(last), sin(last), cos(half), sin(half)

    logic               r_out_valid;
    t_out               r_out;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    logic w_in_acc;
    logic w_out_acc;
    logic w_fire;
    assign w_in_acc  = i_in_valid && o_in_ready;
    assign w_out_acc = r_out_valid && i_out_ready;
    assign w_fire    = (r_state == S_ADD) && (!r_out_valid || i_out_ready);

    // Sine table read port: angle -> index (A * DEPTH) >> 16
    logic [15:0]        w_half;
    logic [15:0]        w_angle;
    logic [16+IDX_W:0]  w_idx_prod;
    logic [IDX_W-1:0]   w_idx;
    assign w_half = {r_head_now[15], r_head_now[15:1]};
    always_comb begin
        case (r_step[1:0])
            2'd0:    w_angle = r_head_last + QUARTER_TURN;
            2'd1:    w_angle = r_head_last;
            2'd2:    w_angle = w_half + QUARTER_TURN;
            default: w_angle = w_half;
        endcase
    end
    assign w_idx_prod = {{(IDX_W+1){1'b0}}, w_angle} * (IDX_W+17)'(SINE_TABLE_DEPTH);
    assign w_idx      = w_idx_prod[16 +: IDX_W];

    always_ff @(posedge i_clk) begin
        r_rom_q <= w_sine[w_idx];
    end

    // Quaternion product operand selection: ww xx yy zz xy wz xz wy yz wx
    logic [1:0] w_qa;
    logic [1:0] w_qb;
    always_comb begin
        case (r_step)
            4'd0:    begin w_qa = 2'd0; w_qb = 2'd0; end
            4'd1:    begin w_qa = 2'd1; w_qb = 2'd1; end
            4'd2:    begin w_qa = 2'd2; w_qb = 2'd2; end
            4'd3:    begin w_qa = 2'd3; w_qb = 2'd3; end
            4'd4:    begin w_qa = 2'd1; w_qb = 2'd2; end
            4'd5:    begin w_qa = 2'd0; w_qb = 2'd3; end
            4'd6:    begin w_qa = 2'd1; w_qb = 2'd3; end
            4'd7:    begin w_qa = 2'd0; w_qb = 2'd2; end
            4'd8:    begin w_qa = 2'd2; w_qb = 2'd3; end
            default: begin w_qa = 2'd0; w_qb = 2'd1; end
        endcase
    end

    // Shared multiplier
    logic signed [17:0] w_ma;
    logic signed [39:0] w_mb;
    logic signed [57:0] w_mul;
    logic signed [59:0] w_mul_x;
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            S_PROD: begin
                w_ma = 18'(r_q[w_qa]);
                w_mb = 40'(r_q[w_qb]);
            end
            S_LOC: begin
                w_ma = r_m[r_row][r_col];
                w_mb = 40'(r_d[r_col]);
            end
            S_ROT: begin
                case (r_step[1:0])
                    2'd0:    begin w_ma = 18'(r_trig[0]);  w_mb = 40'(r_loc[0]); end
                    2'd1:    begin w_ma = -18'(r_trig[1]); w_mb = 40'(r_loc[1]); end
                    2'd2:    begin w_ma = 18'(r_trig[1]);  w_mb = 40'(r_loc[0]); end
                    default: begin w_ma = 18'(r_trig[0]);  w_mb = 40'(r_loc[1]); end
                endcase
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end
    assign w_mul   = w_ma * w_mb;
    assign w_mul_x = 60'(w_mul);

    // Accumulator: a new sum starts at the first column / even rotation step
    logic signed [59:0] w_acc_next;
    logic signed [59:0] w_acc_rnd;
    logic               w_acc_clr;
    assign w_acc_clr  = (r_state == S_LOC) ? (r_col == 2'd0) : !r_step[0];
    assign w_acc_next = (w_acc_clr ? 60'sd0 : r_acc) + w_mul_x;
    assign w_acc_rnd  = (w_acc_next + 60'sd8192) >>> 14;

    // Transposed rotation matrix from the stored products, rounded Q28 -> Q14
    logic signed [31:0] w_p [10];
    logic signed [31:0] w_msum [9];
    always_comb begin
        for (int i = 0; i < 10; i++) begin
            w_p[i] = 32'(r_prod[i]);
        end
        w_msum[0] = w_p[0] + w_p[1] - w_p[2] - w_p[3];
        w_msum[1] = (w_p[4] + w_p[5]) <<< 1;
        w_msum[2] = (w_p[6] - w_p[7]) <<< 1;
        w_msum[3] = (w_p[4] - w_p[5]) <<< 1;
        w_msum[4] = w_p[0] - w_p[1] + w_p[2] - w_p[3];
        w_msum[5] = (w_p[8] + w_p[9]) <<< 1;
        w_msum[6] = (w_p[6] + w_p[7]) <<< 1;
        w_msum[7] = (w_p[8] - w_p[9]) <<< 1;
        w_msum[8] = w_p[0] - w_p[1] - w_p[2] + w_p[3];
    end

    // Saturating pose update
    logic signed [46:0] w_sum [3];
    logic signed [31:0] w_sat [3];
    always_comb begin
        w_sum[0] = 47'(r_fused[0]) + 47'(r_g[0]);
        w_sum[1] = 47'(r_fused[1]) + 47'(r_g[1]);
        w_sum[2] = 47'(r_fused[2]) + 47'(r_loc[2]);
        for (int i = 0; i < 3; i++) begin
            if (w_sum[i] > 47'sd2147483647) begin
                w_sat[i] = 32'sh7FFFFFFF;
            end else if (w_sum[i] < -47'sd2147483648) begin
                w_sat[i] = 32'sh80000000;
            end else begin
                w_sat[i] = w_sum[i][31:0];
            end
        end
    end

    // Sequencer and state
    logic signed [31:0] w_pin [3];
    logic signed [15:0] w_qin [4];
    logic [1:0]         w_trig_sel;
    assign w_pin[0]   = i_in.pos_x;
    assign w_pin[1]   = i_in.pos_y;
    assign w_pin[2]   = i_in.pos_z;
    assign w_qin[0]   = i_in.quat_w;
    assign w_qin[1]   = i_in.quat_x;
    assign w_qin[2]   = i_in.quat_y;
    assign w_qin[3]   = i_in.quat_z;
    assign w_trig_sel = 2'(r_step - 4'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_seen      <= 1'b0;
            r_head_now  <= '0;
            r_head_last <= '0;
            r_out_valid <= 1'b0;
            r_step      <= '0;
            r_row       <= '0;
            r_col       <= '0;
            for (int i = 0; i < 3; i++) begin
                r_fused[i] <= '0;
            end
        end else begin
            // A new result may load in the cycle the old one is taken
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (w_out_acc) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        if (i_in.operation == OP_YAW) begin
                            r_head_now <= r_head_now + i_in.yaw_increment;
                        end else begin
                            r_seen <= 1'b1;
                            for (int i = 0; i < 3; i++) begin
                                r_d[i]      <= r_seen ? 33'(w_pin[i]) - 33'(r_prev_p[i]) : '0;
                                r_prev_p[i] <= w_pin[i];
                            end
                            for (int i = 0; i < 4; i++) begin
                                r_q[i]      <= r_seen ? r_prev_q[i] : w_qin[i];
                                r_prev_q[i] <= w_qin[i];
                            end
                            r_step  <= '0;
                            r_state <= S_PROD;
                        end
                    end
                end
                S_PROD: begin
                    r_prod[r_step] <= w_mul[29:0];
                    if (r_step >= 4'd1 && r_step <= 4'd4) begin
                        r_trig[w_trig_sel] <= r_rom_q;
                    end
                    if (r_step == 4'd9) begin
                        r_state <= S_MATRIX;
                    end
                    r_step <= r_step + 4'd1;
                end
                S_MATRIX: begin
                    for (int i = 0; i < 3; i++) begin
                        for (int j = 0; j < 3; j++) begin
                            r_m[i][j] <= 18'((w_msum[i*3+j] + 32'sd8192) >>> 14);
                        end
                    end
                    r_row   <= '0;
                    r_col   <= '0;
                    r_state <= S_LOC;
                end
                S_LOC: begin
                    r_acc <= w_acc_next;
                    if (r_col == 2'd2) begin
                        r_loc[r_row] <= w_acc_rnd[38:0];
                        r_col        <= '0;
                        r_row        <= r_row + 2'd1;
                        if (r_row == 2'd2) begin
                            r_step  <= '0;
                            r_state <= S_ROT;
                        end
                    end else begin
                        r_col <= r_col + 2'd1;
                    end
                end
                S_ROT: begin
                    r_acc <= w_acc_next;
                    if (r_step[0]) begin
                        r_g[r_step[1]] <= w_acc_rnd[45:0];
                    end
                    if (r_step[1:0] == 2'd3) begin
                        r_state <= S_ADD;
                    end
                    r_step <= r_step + 4'd1;
                end
                S_ADD: begin
                    if (w_fire) begin
                        for (int i = 0; i < 3; i++) begin
                            r_fused[i] <= w_sat[i];
                        end
                        r_head_last <= r_head_now;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out.pose_x   <= w_sat[0];
            r_out.pose_y   <= w_sat[1];
            r_out.pose_z   <= w_sat[2];
            r_out.heading  <= r_head_now;
            r_out.orient_w <= r_trig[2];
            r_out.orient_z <= r_trig[3];
        end
    end

endmodule

`default_nettype wire
